// ===== hdl/heartbeat_liveness_table_assert.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef HEARTBEAT_LIVENESS_TABLE_ASSERT_SVH
`define HEARTBEAT_LIVENESS_TABLE_ASSERT_SVH

// same-cycle implication
`define HLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hlt_pkg.sv =====
`timescale 1ns / 1ps
package hlt_pkg;

  localparam int USER_W  = 16;
  localparam int AGE_W   = 8;
  localparam int ENTRY_W = USER_W + AGE_W;
  localparam int KIND_W  = 2;

  localparam logic [AGE_W-1:0]  AGE_MAX     = 8'd255;
  localparam logic [AGE_W-1:0]  LIMIT_RESET = 8'd5;

  localparam logic [KIND_W-1:0] KIND_OFFLINE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ONLINE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

  localparam logic CMD_HEARTBEAT = 1'b0;
  localparam logic CMD_TICK      = 1'b1;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } hlt_cmp_t;

endpackage

// ===== hdl/hlt_ram.sv =====
`timescale 1ns / 1ps
module hlt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/hlt_cmp.sv =====
`timescale 1ns / 1ps
module hlt_cmp (
  input  logic [hlt_pkg::USER_W-1:0] a,
  input  logic [hlt_pkg::USER_W-1:0] b,
  output hlt_pkg::hlt_cmp_t          res
);
  import hlt_pkg::*;

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
    res.gt = (a > b);
  end

endmodule

// ===== hdl/heartbeat_liveness_table.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_tvalid/tready     tdata {start_age, user_id}, tuser command
// out      out  out_tvalid/tready    tdata event_user, tuser event_kind, tlast last_event
// cfg      in   cfg_we               cfg_wdata age_limit
//
// Every item walks the table through one registered-read RAM port, one entry a cycle.
// Heartbeat: one pass over the table, ended early on a hit. Tick: one aging pass, then
// one min-search pass per removed user.
// Synchronous active-low reset empties the table at once; RAM contents are not cleared.
// A held output stalls the sequencer only when the next result is ready to load.
module heartbeat_liveness_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [hlt_pkg::AGE_W-1:0]    cfg_wdata,   // age_limit
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,    // user_id [15:0], start_age [23:16]
  input  logic [0:0]                   in_tuser,    // command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [hlt_pkg::USER_W-1:0]   out_tdata,   // event_user
  output logic [hlt_pkg::KIND_W-1:0]   out_tuser,   // event_kind
  output logic                         out_tlast    // last_event
);
  import hlt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_HB_SCAN = 6'b000010,
    ST_HB_EMIT = 6'b000100,
    ST_TK_SCAN = 6'b001000,
    ST_TK_FIND = 6'b010000,
    ST_TK_EMIT = 6'b100000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [AGE_W-1:0]       limit_r, limit_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] exp_r, exp_nxt;
  logic [CW-1:0]          exp_cnt_r, exp_cnt_nxt;
  logic [IW-1:0]          rd_idx_r, rd_idx_nxt;
  logic                   rd_done_r, rd_done_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  logic [USER_W-1:0]      hb_user_r, hb_user_nxt;
  logic [AGE_W-1:0]       hb_age_r, hb_age_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic                   min_found_r, min_found_nxt;
  logic [USER_W-1:0]      min_user_r, min_user_nxt;
  logic [IW-1:0]          min_idx_r, min_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [USER_W-1:0]      out_user_r, out_user_nxt;
  logic [KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
  logic [USER_W-1:0]      rd_user;
  logic [AGE_W-1:0]       rd_age, age_inc;
  logic [USER_W-1:0]      cmp_a, cmp_b;
  hlt_cmp_t               cmp_res;
  logic                   scan_st, scan_end, scan_rst, out_free, emit_load;

  hlt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(rd_idx_r),
    .rd_data(ram_rdata)
  );

  hlt_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .res(cmp_res)
  );

  assign rd_user  = ram_rdata[ENTRY_W-1:AGE_W];
  assign rd_age   = ram_rdata[AGE_W-1:0];
  assign age_inc  = (rd_age == AGE_MAX) ? rd_age : rd_age + 8'd1;
  assign scan_st  = (st_r == ST_HB_SCAN) || (st_r == ST_TK_SCAN) || (st_r == ST_TK_FIND);
  assign scan_end = rd_done_r && !chk_vld_r;
  assign ram_re   = scan_st && !rd_done_r;
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_user_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    unique case (st_r)
      ST_TK_SCAN: begin
        cmp_a = {{(USER_W - AGE_W){1'b0}}, rd_age};
        cmp_b = {{(USER_W - AGE_W){1'b0}}, limit_r};
      end
      ST_TK_FIND: begin
        cmp_a = rd_user;
        cmp_b = min_user_r;
      end
      default: begin
        cmp_a = rd_user;
        cmp_b = hb_user_r;
      end
    endcase
  end

  always_comb begin
    st_nxt         = st_r;
    limit_nxt      = cfg_we ? cfg_wdata : limit_r;
    valid_nxt      = valid_r;
    exp_nxt        = exp_r;
    exp_cnt_nxt    = exp_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    rd_done_nxt    = rd_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hb_user_nxt    = hb_user_r;
    hb_age_nxt     = hb_age_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    min_found_nxt  = min_found_r;
    min_user_nxt   = min_user_r;
    min_idx_nxt    = min_idx_r;
    out_user_nxt   = out_user_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = {hb_user_r, hb_age_r};
    scan_rst       = 1'b0;
    emit_load      = 1'b0;

    // advance the read pointer one entry a cycle
    if (scan_st) begin
      chk_vld_nxt = !rd_done_r;
      chk_idx_nxt = rd_idx_r;
      if (!rd_done_r) begin
        if (rd_idx_r == LAST_IDX) begin
          rd_done_nxt = 1'b1;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          hb_user_nxt    = in_tdata[USER_W-1:0];
          hb_age_nxt     = in_tdata[USER_W+AGE_W-1:USER_W];
          free_found_nxt = 1'b0;
          scan_rst       = 1'b1;
          st_nxt         = (in_tuser[0] == CMD_TICK) ? ST_TK_SCAN : ST_HB_SCAN;
        end
      end
      ST_HB_SCAN: begin
        if (chk_vld_r) begin
          if (valid_r[chk_idx_r] && cmp_res.eq) begin
            ram_we    = 1'b1;
            ram_wdata = {hb_user_r, {AGE_W{1'b0}}};
            st_nxt    = ST_IDLE;
          end else if (!valid_r[chk_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
        end
        if (scan_end) begin
          st_nxt = ST_HB_EMIT;
        end
      end
      ST_HB_EMIT: begin
        if (out_free) begin
          emit_load    = 1'b1;
          out_user_nxt = hb_user_r;
          out_kind_nxt = free_found_r ? KIND_ONLINE : KIND_REFUSED;
          out_last_nxt = 1'b1;
          if (free_found_r) begin
            ram_we                = 1'b1;
            ram_waddr             = free_idx_r;
            ram_wdata             = {hb_user_r, hb_age_r};
            valid_nxt[free_idx_r] = 1'b1;
          end
          st_nxt = ST_IDLE;
        end
      end
      ST_TK_SCAN: begin
        if (chk_vld_r && valid_r[chk_idx_r]) begin
          if (cmp_res.gt) begin
            valid_nxt[chk_idx_r] = 1'b0;
            exp_nxt[chk_idx_r]   = 1'b1;
            exp_cnt_nxt          = exp_cnt_r + 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {rd_user, age_inc};
          end
        end
        if (scan_end) begin
          if (exp_cnt_r == '0) begin
            st_nxt = ST_IDLE;
          end else begin
            scan_rst      = 1'b1;
            min_found_nxt = 1'b0;
            st_nxt        = ST_TK_FIND;
          end
        end
      end
      ST_TK_FIND: begin
        if (chk_vld_r && exp_r[chk_idx_r] && (!min_found_r || cmp_res.lt)) begin
          min_found_nxt = 1'b1;
          min_user_nxt  = rd_user;
          min_idx_nxt   = chk_idx_r;
        end
        if (scan_end) begin
          st_nxt = ST_TK_EMIT;
        end
      end
      ST_TK_EMIT: begin
        if (out_free) begin
          emit_load            = 1'b1;
          out_user_nxt         = min_user_r;
          out_kind_nxt         = KIND_OFFLINE;
          out_last_nxt         = (exp_cnt_r == CW'(1));
          exp_nxt[min_idx_r]   = 1'b0;
          exp_cnt_nxt          = exp_cnt_r - 1'b1;
          if (exp_cnt_r == CW'(1)) begin
            st_nxt = ST_IDLE;
          end else begin
            scan_rst      = 1'b1;
            min_found_nxt = 1'b0;
            st_nxt        = ST_TK_FIND;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // restart the walk at entry zero
    if (scan_rst) begin
      rd_idx_nxt  = '0;
      rd_done_nxt = 1'b0;
      chk_vld_nxt = 1'b0;
    end

    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      valid_r     <= '0;
      exp_r       <= '0;
      exp_cnt_r   <= '0;
      rd_done_r   <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      limit_r     <= limit_nxt;
      valid_r     <= valid_nxt;
      exp_r       <= exp_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      rd_done_r   <= rd_done_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hb_user_r    <= hb_user_nxt;
    hb_age_r     <= hb_age_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    min_found_r  <= min_found_nxt;
    min_user_r   <= min_user_nxt;
    min_idx_r    <= min_idx_nxt;
    out_user_r   <= out_user_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
  end

`include "heartbeat_liveness_table_assert.svh"

  `HLT_ASSERT_IMP(a_exp_count, 1'b1, exp_cnt_r == CW'($countones(exp_r)), "expiry count mismatch")
  `HLT_ASSERT_IMP(a_exp_not_live, 1'b1, (exp_r & valid_r) == '0, "expired entry still live")
  `HLT_ASSERT_NXT(a_tick_drain,
    (st_r == ST_TK_EMIT) && out_free && (exp_cnt_r == CW'(1)),
    (exp_r == '0) && (st_r == ST_IDLE), "tick ended with pending removals")

endmodule
